[rtl/core/lbp_pkg.sv]
// Shared types, widths and constants of the LSB-first bit packer.
`default_nettype none

package lbp_pkg;

   localparam int LBP_VALUE_W         = 32;
   localparam int LBP_NUM_BITS_W      = 6;
   localparam int LBP_KIND_W          = 2;
   localparam int LBP_INDEX_W         = 17;
   localparam int LBP_OFFSET_W        = 16;
   localparam int LBP_MAX_SIZE_W      = 17;
   localparam int LBP_BYTE_BITS       = 8;
   localparam int LBP_JOB_BYTES       = 4;
   localparam int LBP_ACC_W           = LBP_VALUE_W + LBP_BYTE_BITS;
   localparam int LBP_WRITE_RESERVE   = 2;
   localparam int LBP_MAX_FIELD_BITS  = 32;
   localparam int LBP_QUEUE_DEPTH     = 4;
   localparam int LBP_REQ_DATA_W      = 40;
   localparam int LBP_RSP_DATA_W      = 24;
   localparam int LBP_CSR_INDEX_W     = 1;
   localparam int LBP_CSR_DATA_W      = 17;
   localparam logic [LBP_MAX_SIZE_W-1:0] LBP_MAX_SIZE_RESET = 17'h10000;

   typedef enum logic [LBP_KIND_W-1:0] {
      KIND_UNSIGNED = 2'd0,
      KIND_SIGNED   = 2'd1,
      KIND_END      = 2'd2
   } lbp_kind_type;

   typedef enum logic [LBP_CSR_INDEX_W-1:0] {
      CSR_START_OFFSET = 1'd0,
      CSR_MAX_SIZE     = 1'd1
   } lbp_csr_index_type;

   typedef struct packed {
      logic                      write_enable;
      logic [LBP_CSR_INDEX_W-1:0] index;
      logic [LBP_CSR_DATA_W-1:0] data;
   } lbp_csr_type;

   typedef struct packed {
      lbp_kind_type              kind;
      logic [LBP_VALUE_W-1:0]    data;
      logic [LBP_NUM_BITS_W-1:0] num_bits;
   } lbp_item_type;

   typedef struct packed {
      logic [LBP_JOB_BYTES*LBP_BYTE_BITS-1:0] bytes;
      logic [2:0]                             count;
      logic [LBP_OFFSET_W-1:0]                offset;
      logic                                   overflowed;
   } lbp_job_type;

endpackage

`default_nettype wire

[rtl/core/lbp_classify.sv]
// Front stage: accept items, drop unknown kinds, clamp the width, saturate and sign-encode the value.
`default_nettype none

module lbp_classify (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [lbp_pkg::LBP_REQ_DATA_W-1:0] req_tdata,
   input  wire logic [lbp_pkg::LBP_KIND_W-1:0]     req_tuser,
   output logic                                   item_valid,
   output lbp_pkg::lbp_item_type                  item,
   input  wire logic                              item_taken
);
   import lbp_pkg::*;

   logic                      item_valid_ff, item_valid_in;
   lbp_item_type              item_ff, item_in;
   logic [LBP_VALUE_W-1:0]    value;
   logic [LBP_NUM_BITS_W-1:0] num_bits_raw, num_bits;
   logic [LBP_VALUE_W-1:0]    mask, limit, magnitude_raw, magnitude;
   logic                      sign_bit, keep;
   lbp_kind_type              kind;

   assign value        = req_tdata[LBP_VALUE_W-1:0];
   assign num_bits_raw = req_tdata[LBP_VALUE_W +: LBP_NUM_BITS_W];
   assign kind         = lbp_kind_type'(req_tuser);

   always_comb begin
      if (num_bits_raw == '0) begin
         num_bits = LBP_NUM_BITS_W'(1);
      end else if (num_bits_raw > LBP_NUM_BITS_W'(LBP_MAX_FIELD_BITS)) begin
         num_bits = LBP_NUM_BITS_W'(LBP_MAX_FIELD_BITS);
      end else begin
         num_bits = num_bits_raw;
      end
   end

   assign mask          = {LBP_VALUE_W{1'b1}} >> (LBP_NUM_BITS_W'(LBP_VALUE_W) - num_bits);
   assign limit         = mask >> 1;
   assign magnitude_raw = value[LBP_VALUE_W-1] ? (~value + LBP_VALUE_W'(1)) : value;
   assign magnitude     = (|(magnitude_raw & ~limit)) ? limit : magnitude_raw;
   assign sign_bit      = value[LBP_VALUE_W-1] && (num_bits != LBP_NUM_BITS_W'(1));

   always_comb begin
      item_in.kind     = kind;
      item_in.num_bits = num_bits;
      item_in.data     = '0;
      keep             = 1'b1;
      case (kind)
         KIND_UNSIGNED: item_in.data = (|(value & ~mask)) ? mask : value;
         KIND_SIGNED:   item_in.data = {magnitude[LBP_VALUE_W-2:0], sign_bit};
         KIND_END:      item_in.data = '0;
         default:       keep = 1'b0;
      endcase
   end

   assign req_tready    = !item_valid_ff || item_taken;
   assign item_valid_in = req_tready ? (req_tvalid && keep) : item_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[rtl/core/lbp_packer.sv]
// Bit position state, space check and byte job generation; configuration registers.
`default_nettype none

module lbp_packer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lbp_pkg::lbp_csr_type  csr,
   input  wire logic                  item_valid,
   input  wire lbp_pkg::lbp_item_type item,
   output logic                       item_taken,
   input  wire logic                  queue_full,
   output logic                       push,
   output lbp_pkg::lbp_job_type       push_job
);
   import lbp_pkg::*;

   localparam int SUM_W = LBP_INDEX_W + 2;

   logic [LBP_BYTE_BITS-1:0]  partial_ff, partial_in;
   logic [3:0]                bit_pos_ff, bit_pos_in;
   logic [LBP_INDEX_W-1:0]    byte_index_ff, byte_index_in;
   logic                      overflow_ff, overflow_in;
   logic [LBP_MAX_SIZE_W-1:0] max_size_ff, max_size_in;

   logic [LBP_BYTE_BITS-1:0]  low_mask, low_bits, new_partial;
   logic [LBP_ACC_W-1:0]      acc;
   logic [LBP_NUM_BITS_W-1:0] total_bits, total_m1;
   logic [2:0]                full_bytes;
   logic [3:0]                new_bit_pos;
   logic [SUM_W-1:0]          need_all, need_one;
   logic                      pass_all, pass_one;

   assign item_taken  = item_valid && !queue_full;

   assign low_mask    = LBP_BYTE_BITS'((9'd1 << bit_pos_ff) - 9'd1);
   assign low_bits    = partial_ff & low_mask;
   assign acc         = (LBP_ACC_W'(item.data) << bit_pos_ff) | LBP_ACC_W'(low_bits);
   assign total_bits  = item.num_bits + LBP_NUM_BITS_W'(bit_pos_ff);
   assign total_m1    = total_bits - LBP_NUM_BITS_W'(1);
   assign full_bytes  = total_m1[5:3];
   assign new_bit_pos = {1'b0, total_m1[2:0]} + 4'd1;
   assign new_partial = acc[{full_bytes, 3'b000} +: LBP_BYTE_BITS];

   assign need_all = SUM_W'(byte_index_ff) + SUM_W'(full_bytes) + SUM_W'(LBP_WRITE_RESERVE);
   assign need_one = SUM_W'(byte_index_ff) + SUM_W'(1) + SUM_W'(LBP_WRITE_RESERVE);
   assign pass_all = need_all <= SUM_W'(max_size_ff);
   assign pass_one = need_one <= SUM_W'(max_size_ff);

   always_comb begin
      partial_in    = partial_ff;
      bit_pos_in    = bit_pos_ff;
      byte_index_in = byte_index_ff;
      overflow_in   = overflow_ff;
      max_size_in   = max_size_ff;
      push          = 1'b0;
      push_job.bytes      = acc[LBP_JOB_BYTES*LBP_BYTE_BITS-1:0];
      push_job.count      = full_bytes;
      push_job.offset     = byte_index_ff[LBP_OFFSET_W-1:0];
      push_job.overflowed = 1'b0;
      if (item_taken) begin
         case (item.kind)
            KIND_UNSIGNED, KIND_SIGNED: begin
               if (!overflow_ff) begin
                  if (pass_all) begin
                     push          = (full_bytes != 3'd0);
                     partial_in    = new_partial;
                     bit_pos_in    = new_bit_pos;
                     byte_index_in = byte_index_ff + LBP_INDEX_W'(full_bytes);
                  end else if ((item.kind == KIND_SIGNED) &&
                               (bit_pos_ff == 4'(LBP_BYTE_BITS)) && pass_one) begin
                     push           = 1'b1;
                     push_job.bytes = {{(LBP_JOB_BYTES-1)*LBP_BYTE_BITS{1'b0}}, partial_ff};
                     push_job.count = 3'd1;
                     partial_in     = {{(LBP_BYTE_BITS-1){1'b0}}, item.data[0]};
                     bit_pos_in     = 4'd1;
                     byte_index_in  = byte_index_ff + LBP_INDEX_W'(1);
                     overflow_in    = 1'b1;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
            end
            KIND_END: begin
               push           = 1'b1;
               push_job.count = 3'd1;
               if (!overflow_ff && pass_one) begin
                  push_job.bytes = {{(LBP_JOB_BYTES-1)*LBP_BYTE_BITS{1'b0}}, low_bits};
                  byte_index_in  = byte_index_ff + LBP_INDEX_W'(1);
               end else begin
                  push_job.bytes      = '0;
                  push_job.overflowed = 1'b1;
                  overflow_in         = 1'b1;
               end
               partial_in = '0;
               bit_pos_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (csr.write_enable) begin
         case (csr.index)
            CSR_START_OFFSET: begin
               byte_index_in = LBP_INDEX_W'(csr.data[LBP_OFFSET_W-1:0]);
               partial_in    = '0;
               bit_pos_in    = '0;
            end
            CSR_MAX_SIZE: max_size_in = csr.data[LBP_MAX_SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff    <= '0;
         bit_pos_ff    <= '0;
         byte_index_ff <= '0;
         overflow_ff   <= 1'b0;
         max_size_ff   <= LBP_MAX_SIZE_RESET;
      end else begin
         partial_ff    <= partial_in;
         bit_pos_ff    <= bit_pos_in;
         byte_index_ff <= byte_index_in;
         overflow_ff   <= overflow_in;
         max_size_ff   <= max_size_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lbp_queue.sv]
// Short job queue between the packer and the byte emitter.
`default_nettype none

module lbp_queue #(
   parameter int DEPTH = lbp_pkg::LBP_QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lbp_pkg::lbp_job_type push_job,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      empty,
   output lbp_pkg::lbp_job_type      head_job
);
   import lbp_pkg::*;

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   lbp_job_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == COUNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + COUNT_W'(1);
         2'b01:   count_in = count_ff - COUNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lbp_emitter.sv]
// Back end: unpack queued jobs into one result item per cycle while rsp_tready is high.
`default_nettype none

module lbp_emitter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               queue_empty,
   input  wire lbp_pkg::lbp_job_type               head_job,
   output logic                                    pop,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [lbp_pkg::LBP_RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                    rsp_tuser,
   output logic                                    rsp_tlast
);
   import lbp_pkg::*;

   logic                                   valid_ff, valid_in;
   logic [2:0]                             remain_ff, remain_in;
   logic [LBP_JOB_BYTES*LBP_BYTE_BITS-1:0] bytes_ff, bytes_in;
   logic [LBP_OFFSET_W-1:0]                offset_ff, offset_in;
   logic                                   overflow_ff, overflow_in;
   logic                                   last, load;

   assign last = (remain_ff == 3'd1);
   assign load = !valid_ff || (rsp_tready && last);
   assign pop  = load && !queue_empty;

   always_comb begin
      valid_in    = valid_ff;
      remain_in   = remain_ff;
      bytes_in    = bytes_ff;
      offset_in   = offset_ff;
      overflow_in = overflow_ff;
      if (load) begin
         valid_in    = !queue_empty;
         remain_in   = head_job.count;
         bytes_in    = head_job.bytes;
         offset_in   = head_job.offset;
         overflow_in = head_job.overflowed;
      end else if (rsp_tready) begin
         remain_in = remain_ff - 3'd1;
         bytes_in  = bytes_ff >> LBP_BYTE_BITS;
         offset_in = offset_ff + LBP_OFFSET_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         remain_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff    <= bytes_in;
      offset_ff   <= offset_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {offset_ff, bytes_ff[LBP_BYTE_BITS-1:0]};
   assign rsp_tuser  = overflow_ff;
   assign rsp_tlast  = last;

endmodule

`default_nettype wire

[rtl/core/lsb_first_bit_packer_unit.sv]
// Top level of the LSB-first bit packer.
//
//   channel | direction | tdata (low bit up)             | tuser      | tlast
//   req     | in        | value[31:0], num_bits[37:32]   | kind[1:0]  | -
//   rsp     | out       | out_byte[7:0], byte_offset[23:8]| overflowed | last
//   csr     | in        | write_enable, index, write_data (17 bits)
//
// One item enters per cycle while the job queue has room; the packer settles
// the bit position and space check in that cycle. The emitter sends one byte
// per cycle while rsp_tready is high; an item emits none to 4 bytes. An
// accepted item passes the classify register, the job queue and the emitter
// register before its first result.
// Synchronous reset clears position, overflow flag and all valid state.
// Stalls on rsp back up through the queue to req_tready.
`default_nettype none

module lsb_first_bit_packer_unit #(
   parameter int QUEUE_DEPTH = lbp_pkg::LBP_QUEUE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // value[31:0], num_bits[37:32], zero[39:38]
   input  wire logic [lbp_pkg::LBP_REQ_DATA_W-1:0]  req_tdata,
   // kind[1:0]
   input  wire logic [lbp_pkg::LBP_KIND_W-1:0]      req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // out_byte[7:0], byte_offset[23:8]
   output logic [lbp_pkg::LBP_RSP_DATA_W-1:0]       rsp_tdata,
   // overflowed[0]
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   input  wire logic                                csr_write_enable,
   input  wire logic [lbp_pkg::LBP_CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lbp_pkg::LBP_CSR_DATA_W-1:0]  csr_write_data
);
   import lbp_pkg::*;

   lbp_csr_type  csr;
   lbp_item_type item;
   lbp_job_type  push_job, head_job;
   logic         item_valid, item_taken, push, queue_full, queue_empty, pop;

   assign csr.write_enable = csr_write_enable;
   assign csr.index        = csr_index;
   assign csr.data         = csr_write_data;

   lbp_classify u_classify (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_taken (item_taken)
   );

   lbp_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .item_valid (item_valid),
      .item       (item),
      .item_taken (item_taken),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   lbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   lbp_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

[rtl/core/lbp_checker.sv]
// Port-level assertions for the bit packer, bound to the top level.
`default_nettype none

module lbp_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [lbp_pkg::LBP_RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                               rsp_tuser,
   input  wire logic                               rsp_tlast
);
   import lbp_pkg::*;

   logic                    seen_overflow_ff, seen_overflow_in;
   logic                    run_ff, run_in;
   logic [LBP_OFFSET_W-1:0] next_offset_ff, next_offset_in;
   logic                    rsp_accept;

   assign rsp_accept = rsp_tvalid && rsp_tready;

   always_comb begin
      seen_overflow_in = seen_overflow_ff || (rsp_accept && rsp_tuser);
      run_in           = rsp_accept ? !rsp_tlast : run_ff;
      next_offset_in   = rsp_accept ? rsp_tdata[LBP_RSP_DATA_W-1:LBP_BYTE_BITS] + LBP_OFFSET_W'(1)
                                    : next_offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_overflow_ff <= 1'b0;
         run_ff           <= 1'b0;
         next_offset_ff   <= '0;
      end else begin
         seen_overflow_ff <= seen_overflow_in;
         run_ff           <= run_in;
         next_offset_ff   <= next_offset_in;
      end
   end

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp item changed");

   a_overflow_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[LBP_BYTE_BITS-1:0] == '0))
      else $error("overflow item not a lone zero byte");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && seen_overflow_ff |-> rsp_tuser)
      else $error("item after overflow without overflow flag");

   a_offset_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && run_ff |-> rsp_tdata[LBP_RSP_DATA_W-1:LBP_BYTE_BITS] == next_offset_ff)
      else $error("byte offsets within one item not consecutive");

endmodule

bind lsb_first_bit_packer_unit lbp_checker u_lbp_checker (.*);

`default_nettype wire
